// ----- rtl/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define MCTU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define MCTU_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/mctu_pkg.sv -----
`default_nettype none

package mctu_pkg;

  // field widths
  localparam int unsigned FuncW    = 2;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ExpChW   = 3;

  // configuration registers
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam logic [TimeW-1:0] TimeoutRst = 32'd1000;

  // command queue between front and back
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;

  typedef enum logic [FuncW-1:0] {
    OpTrigger = 2'd0,
    OpClear   = 2'd1,
    OpReload  = 2'd2,
    OpPoll    = 2'd3
  } op_e;

  // classified command as it sits in the queue
  typedef struct packed {
    op_e              op;
    logic             bad_ch;
    logic [ChanW-1:0] channel;
    logic [TimeW-1:0] now_ms;
  } cmd_t;

  // queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mctu_if.sv -----
`default_nettype none

// command channel
interface mctu_in_if import mctu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [ChanW-1:0] channel;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, func, channel, now_ms, input ready);
  modport sink   (input valid, func, channel, now_ms, output ready);
endinterface

// result channel
interface mctu_out_if import mctu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic              expired;
  logic [ExpChW-1:0] expired_channel;
  logic              last;

  modport source (output valid, status, expired, expired_channel, last, input ready);
  modport sink   (input valid, status, expired, expired_channel, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/mctu_front.sv -----
`default_nettype none

module mctu_front import mctu_pkg::*; #(
  parameter int unsigned CHANNELS = 8
) (
  mctu_in_if.sink  in_i,
  input  q_stat_t  q_stat_i,
  output logic     q_push_o,
  output cmd_t     cmd_o
);

  // accept whenever the queue has room
  assign in_i.ready = !q_stat_i.full;
  assign q_push_o   = in_i.valid && !q_stat_i.full;

  // decode operation and check the channel range, poll ignores the channel
  always_comb begin
    cmd_o.op      = op_e'(in_i.func);
    cmd_o.channel = in_i.channel;
    cmd_o.now_ms  = in_i.now_ms;
    cmd_o.bad_ch  = (cmd_o.op != OpPoll) && (in_i.channel >= ChanW'(CHANNELS));
  end

endmodule

`default_nettype wire

// ----- rtl/mctu_cmd_fifo.sv -----
`default_nettype none

module mctu_cmd_fifo import mctu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  cmd_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mctu_back.sv -----
`default_nettype none

module mctu_back import mctu_pkg::*; #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i,
  input  q_stat_t            q_stat_i,
  input  cmd_t               cmd_i,
  output logic               q_pop_o,
  mctu_out_if.source         out_o
);

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ChIdxW-1:0] LastIdx = ChIdxW'(CHANNELS - 1);

  typedef enum logic [1:0] {
    BkIdle,
    BkScan,
    BkEmit
  } bk_state_e;

  bk_state_e         state_q;
  logic [TimeW-1:0]  timeout_q [NumRegs];
  logic              running_q [CHANNELS];
  logic [TimeW-1:0]  start_q   [CHANNELS];
  logic [ChIdxW-1:0] idx_q;
  logic [CHANNELS-1:0] mask_q;
  logic [TimeW-1:0]  now_q;

  logic              out_valid_q;
  logic              out_status_q;
  logic              out_expired_q;
  logic [ExpChW-1:0] out_ch_q;
  logic              out_last_q;

  logic                slot_free;
  logic [ChIdxW-1:0]   cmd_ch;
  logic [TimeW-1:0]    elapsed;
  logic                hit;
  logic [ChIdxW-1:0]   low_idx;
  logic [CHANNELS-1:0] rest_mask;

  assign slot_free = !out_valid_q || out_o.ready;
  assign q_pop_o   = (state_q == BkIdle) && !q_stat_i.empty && slot_free;
  assign cmd_ch    = cmd_i.channel[ChIdxW-1:0];

  // one elapsed-time compare per scan cycle, modulo 2^32
  assign elapsed = now_q - start_q[idx_q];
  assign hit     = running_q[idx_q] && (elapsed > timeout_q[RegIdxW'(idx_q)]);

  // lowest pending expiry and what is left after reporting it
  always_comb begin
    low_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_idx = ChIdxW'(i);
      end
    end
    rest_mask = mask_q & ~(CHANNELS'(1) << low_idx);
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.expired         = out_expired_q;
  assign out_o.expired_channel = out_ch_q;
  assign out_o.last            = out_last_q;

  // command execution, poll scan and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BkIdle;
      idx_q         <= '0;
      mask_q        <= '0;
      now_q         <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= 1'b0;
      out_expired_q <= 1'b0;
      out_ch_q      <= '0;
      out_last_q    <= 1'b0;
      for (int r = 0; r < NumRegs; r++) begin
        timeout_q[r] <= TimeoutRst;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        running_q[c] <= 1'b0;
        start_q[c]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        timeout_q[cfg_idx_i] <= cfg_data_i;
      end
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        BkIdle: begin
          if (q_pop_o) begin
            if (cmd_i.op == OpPoll) begin
              state_q <= BkScan;
              idx_q   <= '0;
              mask_q  <= '0;
              now_q   <= cmd_i.now_ms;
            end else begin
              out_valid_q   <= 1'b1;
              out_expired_q <= 1'b0;
              out_ch_q      <= '0;
              out_last_q    <= 1'b1;
              out_status_q  <= 1'b0;
              if (cmd_i.bad_ch) begin
                out_status_q <= 1'b1;
              end else begin
                case (cmd_i.op)
                  OpTrigger: begin
                    if (running_q[cmd_ch]) begin
                      out_status_q <= 1'b1;
                    end else begin
                      running_q[cmd_ch] <= 1'b1;
                      start_q[cmd_ch]   <= cmd_i.now_ms;
                    end
                  end
                  OpClear: begin
                    if (running_q[cmd_ch]) begin
                      running_q[cmd_ch] <= 1'b0;
                      start_q[cmd_ch]   <= '0;
                    end
                  end
                  OpReload: begin
                    if (running_q[cmd_ch]) begin
                      start_q[cmd_ch] <= cmd_i.now_ms;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end
        end

        // mark expired channels and return them to idle
        BkScan: begin
          mask_q[idx_q] <= hit;
          if (hit) begin
            running_q[idx_q] <= 1'b0;
            start_q[idx_q]   <= '0;
          end
          if (idx_q == LastIdx) begin
            state_q <= BkEmit;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        // report expiries in rising channel order
        BkEmit: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= 1'b0;
            if (mask_q == '0) begin
              out_expired_q <= 1'b0;
              out_ch_q      <= '0;
              out_last_q    <= 1'b1;
              state_q       <= BkIdle;
            end else begin
              out_expired_q <= 1'b1;
              out_ch_q      <= ExpChW'(low_idx);
              out_last_q    <= (rest_mask == '0);
              mask_q        <= rest_mask;
              if (rest_mask == '0) begin
                state_q <= BkIdle;
              end
            end
          end
        end

        default: state_q <= BkIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multi_channel_timeout_unit.sv -----
`default_nettype none
`include "assert_macros.svh"

// Eight (CHANNELS) one-shot millisecond timeout channels. Each command item
// carries an operation (trigger, clear, reload, poll), a channel number and
// the current free-running millisecond time; every command answers with one
// result, a poll with one result per expired channel in rising channel order
// or a single "nothing expired" result, the final one flagged by last. Items
// enter through a two-entry command queue, so commands are taken while the
// back end is busy or a result waits. Trigger, clear and reload are carried
// out in the back end in the cycle that takes them from the queue. A poll
// is taken from the queue, then scans the channels one channel per cycle
// through the single elapsed-time subtract and compare, then reports its
// results in turn; a result that waits on the result side stalls the back
// end for as long. Timeout registers reset to 1000 ms and should be written
// only while no command is in flight.
module multi_channel_timeout_unit import mctu_pkg::*; #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mctu_in_if.sink            in_i,
  mctu_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i
);

  logic    q_push;
  logic    q_pop;
  cmd_t    cmd_in;
  cmd_t    cmd_out;
  q_stat_t q_stat;
  logic    exp_fire;
  logic    exp_ch_ok;

  // accept and classify
  mctu_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .cmd_o    (cmd_in)
  );

  // command queue
  mctu_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (cmd_in),
    .pop_i  (q_pop),
    .cmd_o  (cmd_out),
    .stat_o (q_stat)
  );

  // channel state, scan and results
  mctu_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_stat_i   (q_stat),
    .cmd_i      (cmd_out),
    .q_pop_o    (q_pop),
    .out_o      (out_o)
  );

  // expiry result on the output and its channel range
  assign exp_fire  = out_o.valid && out_o.expired;
  assign exp_ch_ok = (4'(out_o.expired_channel) < 4'(CHANNELS));

  // queue and result checks
  `MCTU_NEVER(a_push_full, clk_i, rst_ni, q_push && q_stat.full, "push into full queue")
  `MCTU_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && q_stat.empty, "pop from empty queue")
  `MCTU_ASSERT(a_exp_range, clk_i, rst_ni, exp_fire |-> exp_ch_ok, "expiry on unused channel")
  `MCTU_ASSERT(a_exp_ok, clk_i, rst_ni, exp_fire |-> !out_o.status, "expiry with error status")

endmodule

`default_nettype wire
